/* hdl/mhic_pkg.sv */
// Shared types and constants for the magnetometer hard-iron calibration unit.
package mhic_pkg;

  // Default build-time values
  localparam int RUN_LENGTH_DEF = 300;
  localparam int LED_COUNT_DEF  = 25;

  // Field widths
  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int LEDS_W    = 5;
  localparam int BYTES_W   = 48;

  // Extreme trackers start just inside the 16-bit range
  localparam logic signed [SAMPLE_W-1:0] EXT_MIN_INIT = 16'sd32765;
  localparam logic signed [SAMPLE_W-1:0] EXT_MAX_INIT = -16'sd32765;

  localparam logic [CFG_W-1:0] THR_RESET     = 16'd700;
  localparam logic [7:0]       LOW_BYTE_MASK = 8'hFE;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_CHIP_TYPE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_THR_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_THR_B = 2'd2;

  // Run status codes
  typedef enum logic [1:0] {
    ST_RUN    = 2'd0,
    ST_OK     = 2'd1,
    ST_FAIL   = 2'd2,
    ST_CANCEL = 2'd3
  } status_t;

  // Control broadcast from the merge stage to every axis lane
  typedef struct packed {
    logic             start;
    logic             take;
    logic             chip_type;
    logic [CFG_W-1:0] thr;
  } lane_ctrl_t;

  // What one axis lane reports back
  typedef struct packed {
    logic                       wide;
    logic signed [SAMPLE_W-1:0] offset;
    logic [15:0]                bytes;
  } lane_res_t;

  // One result transaction
  typedef struct packed {
    status_t                    status;
    logic [LEDS_W-1:0]          leds;
    logic signed [SAMPLE_W-1:0] off_x;
    logic signed [SAMPLE_W-1:0] off_y;
    logic signed [SAMPLE_W-1:0] off_z;
    logic [BYTES_W-1:0]         bytes;
  } result_t;

endpackage

/* hdl/mhic_lane.sv */
// One axis lane: min/max tracking, span check, offset and byte packing.
module mhic_lane (
  input  logic                                  clk,
  input  logic                                  rst,
  input  mhic_pkg::lane_ctrl_t                  ctrl,
  input  logic signed [mhic_pkg::SAMPLE_W-1:0]  sample,
  output mhic_pkg::lane_res_t                   res
);

  logic signed [mhic_pkg::SAMPLE_W-1:0] min_v;
  logic signed [mhic_pkg::SAMPLE_W-1:0] max_v;
  logic signed [mhic_pkg::SAMPLE_W-1:0] base_min;
  logic signed [mhic_pkg::SAMPLE_W-1:0] base_max;
  logic signed [mhic_pkg::SAMPLE_W-1:0] min_next;
  logic signed [mhic_pkg::SAMPLE_W-1:0] max_next;
  logic [mhic_pkg::SAMPLE_W:0]          span;
  logic                                 wide;
  logic signed [mhic_pkg::SAMPLE_W:0]   sum;
  logic signed [mhic_pkg::SAMPLE_W:0]   sum_adj;
  logic signed [mhic_pkg::SAMPLE_W:0]   half;
  logic [mhic_pkg::SAMPLE_W-1:0]        off_u;
  logic [7:0]                           b0;
  logic [7:0]                           b1;

  // Extremes update; a new run restarts from the init values
  always_comb begin
    base_min = ctrl.start ? mhic_pkg::EXT_MIN_INIT : min_v;
    base_max = ctrl.start ? mhic_pkg::EXT_MAX_INIT : max_v;
    min_next = (ctrl.take && (sample < base_min)) ? sample : base_min;
    max_next = (ctrl.take && (sample > base_max)) ? sample : base_max;
  end

  // Span check; max never falls below min once a sample is in
  always_comb begin
    span = 17'({max_next[15], max_next} - {min_next[15], min_next});
    wide = span > {1'b0, ctrl.thr};
  end

  // Midpoint, truncated toward zero
  always_comb begin
    sum     = 17'($signed({max_next[15], max_next}) + $signed({min_next[15], min_next}));
    sum_adj = 17'(sum + $signed({16'd0, sum[16]}));
    half    = sum_adj >>> 1;
    off_u   = half[15:0];
  end

  // Chip byte formats
  always_comb begin
    if (ctrl.chip_type) begin
      b0 = off_u[14:7];
      b1 = {off_u[6:0], 1'b0} & mhic_pkg::LOW_BYTE_MASK;
    end else begin
      b0 = off_u[7:0];
      b1 = off_u[15:8];
    end
    res.wide   = wide;
    res.offset = $signed(off_u);
    res.bytes  = {b1, b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_v <= mhic_pkg::EXT_MIN_INIT;
      max_v <= mhic_pkg::EXT_MAX_INIT;
    end else if (ctrl.take) begin
      min_v <= min_next;
      max_v <= max_next;
    end
  end

`ifndef SYNTHESIS
  // After a sample is folded in, the extremes bracket it
  a_lane_order: assert property (@(posedge clk) disable iff (rst)
    ctrl.take |=> (max_v >= min_v))
    else $error("lane max below min after update");
`endif

endmodule

/* hdl/mhic_merge.sv */
// Run control: combines lane span checks, tracks count, progress and status.
module mhic_merge #(
  parameter int RUN_LENGTH = mhic_pkg::RUN_LENGTH_DEF,
  parameter int LED_COUNT  = mhic_pkg::LED_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          start_run,
  input  logic                          cancel,
  input  logic                          chip_type,
  input  logic [mhic_pkg::CFG_W-1:0]    thr_a,
  input  logic [mhic_pkg::CFG_W-1:0]    thr_b,
  input  mhic_pkg::lane_res_t           lane_res [3],
  output mhic_pkg::lane_ctrl_t          ctrl,
  output mhic_pkg::result_t             result
);

  localparam int DIV_RAW  = RUN_LENGTH / LED_COUNT;
  localparam int DIV      = (DIV_RAW == 0) ? 1 : DIV_RAW;
  localparam int PH_W     = (DIV > 1) ? $clog2(DIV) : 1;
  localparam int CNT_W    = $clog2(RUN_LENGTH + 1);
  localparam int LED_CAP  = (LED_COUNT < 31) ? LED_COUNT : 31;
  localparam int HALF_RUN = RUN_LENGTH / 2;
  localparam logic [5:0]       LED_CAP_V  = 6'(LED_CAP);
  localparam logic [PH_W-1:0]  PH_LAST    = PH_W'(DIV - 1);
  localparam logic [CNT_W-1:0] HALF_V     = CNT_W'(HALF_RUN);
  localparam logic [CNT_W-1:0] LAST_IDX   = CNT_W'(RUN_LENGTH - 1);

  mhic_pkg::status_t      run_status;
  mhic_pkg::status_t      run_status_next;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       idx;
  logic [PH_W-1:0]        phase;
  logic [PH_W-1:0]        phase_next;
  logic [PH_W-1:0]        base_phase;
  logic [5:0]             prog;
  logic [5:0]             prog_next;
  logic [5:0]             base_prog;
  logic [5:0]             prog_inc;
  logic [mhic_pkg::LEDS_W-1:0] led_val;
  logic [mhic_pkg::LEDS_W-1:0] leds_hold;
  logic                   start;
  logic                   take;
  logic                   all_wide;
  logic                   ok;

  // Lane broadcast
  always_comb begin
    start          = accept && start_run;
    take           = accept && (start_run || (run_status == mhic_pkg::ST_RUN));
    ctrl.start     = start;
    ctrl.take      = take;
    ctrl.chip_type = chip_type;
    ctrl.thr       = chip_type ? thr_a : thr_b;
  end

  // Progress: quotient kept incrementally, phase counts within one step
  always_comb begin
    idx        = start ? '0 : count;
    base_phase = start ? '0 : phase;
    base_prog  = start ? '0 : prog;
    prog_inc   = base_prog + 6'd1;
    led_val    = (prog_inc > LED_CAP_V) ? LED_CAP_V[4:0] : prog_inc[4:0];
    if (base_phase == PH_LAST) begin
      phase_next = '0;
      prog_next  = (prog_inc > LED_CAP_V) ? LED_CAP_V : prog_inc;
    end else begin
      phase_next = base_phase + PH_W'(1);
      prog_next  = base_prog;
    end
  end

  // Status: cancel, then success, then end of run
  always_comb begin
    all_wide = lane_res[0].wide && lane_res[1].wide && lane_res[2].wide;
    run_status_next = run_status;
    if (take) begin
      if (cancel) begin
        run_status_next = mhic_pkg::ST_CANCEL;
      end else if (all_wide && (idx > HALF_V)) begin
        run_status_next = mhic_pkg::ST_OK;
      end else if (idx >= LAST_IDX) begin
        run_status_next = mhic_pkg::ST_FAIL;
      end else begin
        run_status_next = mhic_pkg::ST_RUN;
      end
    end
  end

  // Result assembly
  always_comb begin
    ok            = (run_status_next == mhic_pkg::ST_OK);
    result.status = run_status_next;
    result.leds   = take ? led_val : leds_hold;
    result.off_x  = ok ? lane_res[0].offset : '0;
    result.off_y  = ok ? lane_res[1].offset : '0;
    result.off_z  = ok ? lane_res[2].offset : '0;
    result.bytes  = ok ? {lane_res[2].bytes, lane_res[1].bytes, lane_res[0].bytes} : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_status <= mhic_pkg::ST_RUN;
      count      <= '0;
      phase      <= '0;
      prog       <= '0;
      leds_hold  <= '0;
    end else if (take) begin
      run_status <= run_status_next;
      count      <= idx + CNT_W'(1);
      phase      <= phase_next;
      prog       <= prog_next;
      leds_hold  <= led_val;
    end
  end

`ifndef SYNTHESIS
  // A new run uses its first sample at once
  a_start_count: assert property (@(posedge clk) disable iff (rst)
    start |=> (count == CNT_W'(1)))
    else $error("count not one after run start");

  // An ended run holds its count until restarted
  a_ended_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && !start_run && (run_status != mhic_pkg::ST_RUN)) |=> $stable(count))
    else $error("count moved on ended run");

  // Count never passes the run length
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(RUN_LENGTH))
    else $error("count beyond run length");
`endif

endmodule

/* hdl/mhic_outq.sv */
// Two-entry output queue so input keeps flowing while a result waits.
module mhic_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mhic_pkg::result_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mhic_pkg::result_t out_data
);

  mhic_pkg::result_t q0;
  mhic_pkg::result_t q1;
  logic              v0;
  logic              v1;
  logic              push;
  logic              pop;

  assign in_ready  = !v1;
  assign push      = in_valid && !v1;
  assign pop       = v0 && out_ready;
  assign out_valid = v0;
  assign out_data  = q0;

  // Head in q0, overflow in q1
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (pop) begin
      if (v1) begin
        q0 <= q1;
        v1 <= 1'b0;
      end else if (push) begin
        q0 <= in_data;
      end else begin
        v0 <= 1'b0;
      end
    end else if (push) begin
      if (!v0) begin
        q0 <= in_data;
        v0 <= 1'b1;
      end else begin
        q1 <= in_data;
        v1 <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // Second slot only fills behind a full head
  a_fill_order: assert property (@(posedge clk) disable iff (rst)
    v1 |-> v0)
    else $error("queue tail valid with empty head");

  // An empty queue cannot be full in the next cycle
  a_no_jump: assert property (@(posedge clk) disable iff (rst)
    !v0 |=> !v1)
    else $error("queue went from empty to full");
`endif

endmodule

/* hdl/magnetometer_hard_iron_calibration_unit.sv */
// Top level of the magnetometer hard-iron calibration unit.
//
// Input channel (in_valid/in_ready): one three-axis sample per transaction,
// with start_run to begin a new run and cancel to abort the current one.
// Output channel (out_valid/out_ready): exactly one result per input
// transaction: run status, progress LED count, and on success the
// hard-iron offsets per axis plus the six packed register bytes.
// Three axis lanes track min/max and midpoints side by side; a merge
// stage combines their span checks into the run status.
// Each result is registered in the output queue on acceptance. Throughput is
// one transaction per cycle while in_ready is high. A two-entry output queue
// holds results when the receiver stalls; in_ready drops only once both
// entries are full.
// Reset (rst, synchronous) clears the queue, starts a run with fresh
// extremes and loads chip_type 0 and both span thresholds with 700.
// Config writes (cfg_wen, cfg_index, cfg_data) take effect on the next
// cycle and should only be made while no transaction is in flight.
module magnetometer_hard_iron_calibration_unit #(
  parameter int RUN_LENGTH = mhic_pkg::RUN_LENGTH_DEF,
  parameter int LED_COUNT  = mhic_pkg::LED_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [mhic_pkg::SAMPLE_W-1:0]  sample_x,
  input  logic signed [mhic_pkg::SAMPLE_W-1:0]  sample_y,
  input  logic signed [mhic_pkg::SAMPLE_W-1:0]  sample_z,
  input  logic                                  start_run,
  input  logic                                  cancel,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            status,
  output logic [mhic_pkg::LEDS_W-1:0]           leds_lit,
  output logic signed [mhic_pkg::SAMPLE_W-1:0]  hi_off_x,
  output logic signed [mhic_pkg::SAMPLE_W-1:0]  hi_off_y,
  output logic signed [mhic_pkg::SAMPLE_W-1:0]  hi_off_z,
  output logic [mhic_pkg::BYTES_W-1:0]          offset_bytes,
  input  logic                                  cfg_wen,
  input  logic [mhic_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mhic_pkg::CFG_W-1:0]            cfg_data
);

  logic                                 chip_type;
  logic [mhic_pkg::CFG_W-1:0]           thr_a;
  logic [mhic_pkg::CFG_W-1:0]           thr_b;
  logic                                 accept;
  logic signed [mhic_pkg::SAMPLE_W-1:0] samples [3];
  mhic_pkg::lane_ctrl_t                 ctrl;
  mhic_pkg::lane_res_t                  lane_res [3];
  mhic_pkg::result_t                    result;
  mhic_pkg::result_t                    out_data;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chip_type <= 1'b0;
      thr_a     <= mhic_pkg::THR_RESET;
      thr_b     <= mhic_pkg::THR_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        mhic_pkg::CFG_CHIP_TYPE:  chip_type <= cfg_data[0];
        mhic_pkg::CFG_SPAN_THR_A: thr_a     <= cfg_data;
        mhic_pkg::CFG_SPAN_THR_B: thr_b     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept     = in_valid && in_ready;
  assign samples[0] = sample_x;
  assign samples[1] = sample_y;
  assign samples[2] = sample_z;

  // Axis lanes
  for (genvar a = 0; a < 3; a++) begin : g_lane
    mhic_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .sample (samples[a]),
      .res    (lane_res[a])
    );
  end

  // Merge and run control
  mhic_merge #(
    .RUN_LENGTH (RUN_LENGTH),
    .LED_COUNT  (LED_COUNT)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .start_run (start_run),
    .cancel    (cancel),
    .chip_type (chip_type),
    .thr_a     (thr_a),
    .thr_b     (thr_b),
    .lane_res  (lane_res),
    .ctrl      (ctrl),
    .result    (result)
  );

  // Output queue
  mhic_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign status       = out_data.status;
  assign leds_lit     = out_data.leds;
  assign hi_off_x     = out_data.off_x;
  assign hi_off_y     = out_data.off_y;
  assign hi_off_z     = out_data.off_z;
  assign offset_bytes = out_data.bytes;

endmodule

/* verif/hard_iron_checker.sv */
// Checker for the hard-iron calibration unit: predicts each result and compares it.
`timescale 1ns / 1ps

module hard_iron_checker #(
  parameter int RUN_LENGTH = mhic_pkg::RUN_LENGTH_DEF,
  parameter int LED_COUNT  = mhic_pkg::LED_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic signed [mhic_pkg::SAMPLE_W-1:0]  sample_x,
  input  logic signed [mhic_pkg::SAMPLE_W-1:0]  sample_y,
  input  logic signed [mhic_pkg::SAMPLE_W-1:0]  sample_z,
  input  logic                                  start_run,
  input  logic                                  cancel,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [1:0]                            status,
  input  logic [mhic_pkg::LEDS_W-1:0]           leds_lit,
  input  logic signed [mhic_pkg::SAMPLE_W-1:0]  hi_off_x,
  input  logic signed [mhic_pkg::SAMPLE_W-1:0]  hi_off_y,
  input  logic signed [mhic_pkg::SAMPLE_W-1:0]  hi_off_z,
  input  logic [mhic_pkg::BYTES_W-1:0]          offset_bytes,
  input  logic                                  cfg_wen,
  input  logic [mhic_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mhic_pkg::CFG_W-1:0]            cfg_data,
  output int                                    fail_count,
  output int                                    pending_count
);

  // Shadow copy of the configuration
  logic                       chip_sel;
  logic [mhic_pkg::CFG_W-1:0] thr_a;
  logic [mhic_pkg::CFG_W-1:0] thr_b;

  // Shadow copy of the calibration state
  int                  min_v [3];
  int                  max_v [3];
  logic [8:0]          sample_count;
  mhic_pkg::status_t   run_state;

  mhic_pkg::result_t calib_results_q [$];
  int                mismatches = 0;

  function automatic void begin_run();
    for (int a = 0; a < 3; a++) begin
      min_v[a] = int'(mhic_pkg::EXT_MIN_INIT);
      max_v[a] = int'(mhic_pkg::EXT_MAX_INIT);
    end
    sample_count = '0;
    run_state = mhic_pkg::ST_RUN;
  endfunction

  function automatic logic [mhic_pkg::LEDS_W-1:0] progress_leds(int idx);
    int d;
    int n;
    d = RUN_LENGTH / LED_COUNT;
    if (d == 0) d = 1;
    n = idx / d + 1;
    if (n > LED_COUNT) n = LED_COUNT;
    if (n > 31) n = 31;
    return mhic_pkg::LEDS_W'(n);
  endfunction

  // One sample in, one calibration result out; updates the shadow state
  function automatic mhic_pkg::result_t predict_calibration(
      input logic signed [mhic_pkg::SAMPLE_W-1:0] sx, sy, sz, input logic st, cn);
    mhic_pkg::result_t                    r;
    int                                   smp [3];
    logic signed [mhic_pkg::SAMPLE_W-1:0] offs [3];
    int                                   idx;
    int                                   span;
    int                                   mid;
    logic [mhic_pkg::CFG_W-1:0]           thr;
    logic [15:0]                          u;
    logic [15:0]                          v;
    logic                                 wide;
    r = '0;
    smp[0] = int'(sx);
    smp[1] = int'(sy);
    smp[2] = int'(sz);
    for (int a = 0; a < 3; a++) offs[a] = '0;
    if (st) begin_run();

    if (run_state == mhic_pkg::ST_RUN) begin
      idx = int'(sample_count);
      thr = chip_sel ? thr_a : thr_b;
      wide = 1'b1;
      for (int a = 0; a < 3; a++) begin
        if (min_v[a] > smp[a]) min_v[a] = smp[a];
        if (max_v[a] < smp[a]) max_v[a] = smp[a];
        span = max_v[a] - min_v[a];
        if (span < 0) span = -span;
        if (!(span > int'(thr))) wide = 1'b0;
      end
      sample_count = 9'(idx + 1);
      r.leds = progress_leds(idx);
      // cancel wins over success, success over running out of samples
      if (cn) run_state = mhic_pkg::ST_CANCEL;
      else if (wide && idx > RUN_LENGTH / 2) run_state = mhic_pkg::ST_OK;
      else if (idx + 1 >= RUN_LENGTH) run_state = mhic_pkg::ST_FAIL;
    end else if (sample_count > 0) begin
      r.leds = progress_leds(int'(sample_count) - 1);
    end

    // Offsets and packed register bytes only on success
    if (run_state == mhic_pkg::ST_OK) begin
      for (int a = 0; a < 3; a++) begin
        mid = (max_v[a] + min_v[a]) / 2;
        u = mid[15:0];
        offs[a] = u;
        if (chip_sel) begin
          v = {u[14:0], 1'b0};
          r.bytes[16*a +: 8] = v[15:8];
          r.bytes[16*a+8 +: 8] = v[7:0] & mhic_pkg::LOW_BYTE_MASK;
        end else begin
          r.bytes[16*a +: 8] = u[7:0];
          r.bytes[16*a+8 +: 8] = u[15:8];
        end
      end
    end
    r.status = run_state;
    r.off_x = offs[0];
    r.off_y = offs[1];
    r.off_z = offs[2];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [47:0] want, got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Watch config writes and both channels
  always @(posedge clk) begin
    mhic_pkg::result_t want;
    if (rst) begin
      chip_sel = 1'b0;
      thr_a = mhic_pkg::THR_RESET;
      thr_b = mhic_pkg::THR_RESET;
      begin_run();
      calib_results_q.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          mhic_pkg::CFG_CHIP_TYPE:  chip_sel = cfg_data[0];
          mhic_pkg::CFG_SPAN_THR_A: thr_a = cfg_data;
          mhic_pkg::CFG_SPAN_THR_B: thr_b = cfg_data;
          default: ;
        endcase
      end
      // compare before queueing, so a result can never match its own input
      if (out_valid && out_ready) begin
        if (calib_results_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result transaction with nothing expected", $time);
          mismatches++;
        end else begin
          want = calib_results_q.pop_front();
          check_field("status", 48'(want.status), 48'(status));
          check_field("leds_lit", 48'(want.leds), 48'(leds_lit));
          check_field("hi_off_x", 48'(want.off_x), 48'(hi_off_x));
          check_field("hi_off_y", 48'(want.off_y), 48'(hi_off_y));
          check_field("hi_off_z", 48'(want.off_z), 48'(hi_off_z));
          check_field("offset_bytes", want.bytes, offset_bytes);
        end
      end
      if (in_valid && in_ready)
        calib_results_q.push_back(
          predict_calibration(sample_x, sample_y, sample_z, start_run, cancel));
    end
    fail_count <= mismatches;
    pending_count <= calib_results_q.size();
  end

endmodule

/* verif/testbench.sv */
// Top of the testbench: clock, reset, sample stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [mhic_pkg::SAMPLE_W-1:0] FULL_POS = 16'sh7FFF;
  localparam logic signed [mhic_pkg::SAMPLE_W-1:0] FULL_NEG = 16'sh8000;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic signed [mhic_pkg::SAMPLE_W-1:0] sample_x = '0;
  logic signed [mhic_pkg::SAMPLE_W-1:0] sample_y = '0;
  logic signed [mhic_pkg::SAMPLE_W-1:0] sample_z = '0;
  logic                                 start_run = 1'b0;
  logic                                 cancel = 1'b0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic [1:0]                           status;
  logic [mhic_pkg::LEDS_W-1:0]          leds_lit;
  logic signed [mhic_pkg::SAMPLE_W-1:0] hi_off_x;
  logic signed [mhic_pkg::SAMPLE_W-1:0] hi_off_y;
  logic signed [mhic_pkg::SAMPLE_W-1:0] hi_off_z;
  logic [mhic_pkg::BYTES_W-1:0]         offset_bytes;
  logic                                 cfg_wen = 1'b0;
  logic [mhic_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [mhic_pkg::CFG_W-1:0]           cfg_data = '0;

  int       fail_count;
  int       pending_count;
  int       cycle_count = 0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_phase = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  magnetometer_hard_iron_calibration_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample_x(sample_x), .sample_y(sample_y), .sample_z(sample_z),
    .start_run(start_run), .cancel(cancel),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .leds_lit(leds_lit),
    .hi_off_x(hi_off_x), .hi_off_y(hi_off_y), .hi_off_z(hi_off_z),
    .offset_bytes(offset_bytes),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hard_iron_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample_x(sample_x), .sample_y(sample_y), .sample_z(sample_z),
    .start_run(start_run), .cancel(cancel),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .leds_lit(leds_lit),
    .hi_off_x(hi_off_x), .hi_off_y(hi_off_y), .hi_off_z(hi_off_z),
    .offset_bytes(offset_bytes),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Receiver: alternates open, coin-flip, sparse and periodic stall stretches
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 150);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= (rx_phase % 8) < 5;
    endcase
  end

  // One input transaction; sender idles between bursts of random length
  task automatic send_sample(input logic signed [mhic_pkg::SAMPLE_W-1:0] x, y, z,
                             input logic st, cn);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    sample_x <= x;
    sample_y <= y;
    sample_z <= z;
    start_run <= st;
    cancel <= cn;
    do @(posedge clk); while (!in_ready);
  endtask

  // Let every outstanding result come out, then a few quiet cycles
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mhic_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mhic_pkg::CFG_W-1:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  // Reading around a center; some readings pinned to full scale
  function automatic logic signed [mhic_pkg::SAMPLE_W-1:0] axis_value(int center, amp,
                                                                       edge_pct);
    int v;
    if ($urandom_range(0, 99) < edge_pct)
      return $urandom_range(0, 1) ? FULL_POS : FULL_NEG;
    v = center + int'($urandom_range(0, 2 * amp)) - amp;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // A run: starts on the first sample, optionally cancelled on the last
  task automatic drive_run(input int len, amp, edge_pct, input logic cancel_last);
    int i;
    int cx, cy, cz;
    cx = int'($urandom_range(0, 32000)) - 16000;
    cy = int'($urandom_range(0, 32000)) - 16000;
    cz = int'($urandom_range(0, 32000)) - 16000;
    for (i = 0; i < len; i++)
      send_sample(axis_value(cx, amp, edge_pct), axis_value(cy, amp, edge_pct),
                  axis_value(cz, amp, edge_pct), i == 0, cancel_last && i == len - 1);
  endtask

  // Unstructured traffic with occasional starts and cancels
  task automatic drive_noise(input int n);
    int i;
    for (i = 0; i < n; i++)
      send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom_range(0, 24) == 0, $urandom_range(0, 24) == 0);
  endtask

  initial begin
    int i;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: full-scale readings, cancel, ended run, restarts
    send_sample(FULL_NEG, FULL_POS, 16'sd0, 1'b0, 1'b0);
    send_sample(FULL_POS, FULL_NEG, -16'sd1, 1'b0, 1'b0);
    send_sample(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1);
    send_sample(16'sd5, -16'sd5, 16'sd1, 1'b0, 1'b0);
    send_sample(16'sd7, 16'sd7, 16'sd7, 1'b0, 1'b1);
    send_sample(FULL_POS, FULL_POS, FULL_NEG, 1'b1, 1'b1);
    send_sample(FULL_NEG, FULL_NEG, FULL_NEG, 1'b1, 1'b0);
    send_sample(16'sd32766, -16'sd32766, 16'sd32765, 1'b1, 1'b0);
    send_sample(-16'sd32765, 16'sd32765, -16'sd32766, 1'b0, 1'b0);
    send_sample(16'sd1000, -16'sd1000, FULL_POS, 1'b1, 1'b0);
    send_sample(16'sh5555, 16'shAAAA, 16'sh00FF, 1'b0, 1'b0);
    send_sample(16'shAAAA, 16'sh5555, 16'shFF00, 1'b0, 1'b1);
    send_sample(16'sd1, 16'sd2, 16'sd3, 1'b0, 1'b0);

    // Reset config: one success run, short cancelled runs, noise
    drive_run($urandom_range(155, 165), $urandom_range(8000, 16000), 2, 1'b0);
    for (i = 0; i < 2; i++) drive_run($urandom_range(1, 30), 3000, 5, 1'b1);
    drive_noise(15);
    drain();

    // Chip 1 with zero threshold: any nonzero span counts
    write_reg(mhic_pkg::CFG_CHIP_TYPE, 16'd1);
    write_reg(mhic_pkg::CFG_SPAN_THR_A, 16'd0);
    write_reg(mhic_pkg::CFG_SPAN_THR_B, 16'hFFFF);
    drive_run($urandom_range(155, 165), $urandom_range(50, 300), 0, 1'b0);
    drive_run($urandom_range(1, 40), 16000, 3, 1'b1);
    drive_noise(10);
    drain();

    // Chip 0 with an unreachable threshold: the run runs out and fails
    write_reg(mhic_pkg::CFG_CHIP_TYPE, 16'd0);
    drive_run(300 + $urandom_range(2, 6), $urandom_range(100, 20000), 3, 1'b0);
    drain();

    // Chip 0 with a large threshold
    write_reg(mhic_pkg::CFG_SPAN_THR_B, 16'd30000);
    write_reg(mhic_pkg::CFG_SPAN_THR_A, 16'd12345);
    drive_run($urandom_range(1, 60), 20000, 2, 1'b1);
    drive_noise(30);
    drain();

    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/mhic_pkg.sv
hdl/mhic_lane.sv
hdl/mhic_merge.sv
hdl/mhic_outq.sv
hdl/magnetometer_hard_iron_calibration_unit.sv
verif/hard_iron_checker.sv
verif/testbench.sv
